### src/sara_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sara_pkg
// shared types and codes for the shelf atlas rectangle allocator
// ----------------------------------------------------------------------------
package sara_pkg;

    // operation codes
    localparam logic OP_PLACE = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_INVALID     = 3'd1;
    localparam logic [2:0] ST_OVERFLOW_X  = 3'd2;
    localparam logic [2:0] ST_LOCKED      = 3'd3;
    localparam logic [2:0] ST_RESIZE_FAIL = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_ATLAS_WIDTH    = 3'd0;
    localparam logic [2:0] REG_INITIAL_HEIGHT = 3'd1;
    localparam logic [2:0] REG_PAD_X          = 3'd2;
    localparam logic [2:0] REG_PAD_Y          = 3'd3;
    localparam logic [2:0] REG_GROWTH_LOCKED  = 3'd4;

    // register reset values
    localparam logic [12:0] RESET_ATLAS_WIDTH    = 13'd1024;
    localparam logic [14:0] RESET_INITIAL_HEIGHT = 15'd256;

    // cursor saturation limits
    localparam logic [12:0] CURSOR_X_MAX = 13'h1FFF;
    localparam logic [14:0] CURSOR_Y_MAX = 15'h7FFF;

    // working width for sums of cursor, size, pad and row height
    typedef logic [17:0] wide_t;

    typedef struct packed {
        logic [12:0] atlas_width;
        logic [7:0]  pad_x;
        logic [7:0]  pad_y;
        logic        growth_locked;
    } cfg_t;

    typedef struct packed {
        logic        load_height;
        logic [14:0] height_value;
        logic        home;
        logic [7:0]  home_x;
        logic [7:0]  home_y;
    } cfg_evt_t;

    typedef struct packed {
        logic [12:0] cursor_x;
        logic [14:0] cursor_y;
        logic [14:0] row_tallest;
        logic [14:0] height_now;
        logic        anything_placed;
    } shelf_state_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] offset_x;
        logic [13:0] offset_y;
        logic [14:0] current_height;
        logic        grew;
    } result_t;

endpackage
`default_nettype wire

### src/sara_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sara_if
// request, response and configuration channels of the atlas allocator
// ----------------------------------------------------------------------------

interface sara_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [12:0] rect_width;
    logic [14:0] rect_height;

    modport source (output valid, output operation, output rect_width,
                    output rect_height, input ready);
    modport sink   (input valid, input operation, input rect_width,
                    input rect_height, output ready);
endinterface

interface sara_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [11:0] offset_x;
    logic [13:0] offset_y;
    logic [14:0] current_height;
    logic        grew;

    modport source (output valid, output status, output offset_x, output offset_y,
                    output current_height, output grew, input ready);
    modport sink   (input valid, input status, input offset_x, input offset_y,
                    input current_height, input grew, output ready);
endinterface

interface sara_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [14:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/shelf_atlas_rect_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shelf_atlas_rect_allocator_core
// shelf allocator for rectangles in an atlas of fixed width and growable height
// ----------------------------------------------------------------------------
// Each request beat either places one rectangle or clears the atlas, and each
// produces exactly one response beat with status, offset, atlas height and a
// grew flag. The block takes one request per clock while the response
// register has room; a beat waits in the request register, where the shelf
// state (cursor, row height, atlas height) is checked and updated in a single
// pass, and the result lands in the response register, which drives the
// response. The shelf state is updated at the edge the result is registered,
// which lets the next beat see it right away. Configuration writes are taken
// every cycle and must only come while no request is in flight; writing the
// initial height reloads the atlas height, and writing a pad while nothing is
// placed moves the cursor home.
module shelf_atlas_rect_allocator_core
    import sara_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 16384
)
(
    input  logic clk,
    input  logic rst_n,
    sara_req_if.sink   req,
    sara_rsp_if.source rsp,
    sara_cfg_if.sink   cfg
);

    // atlas height never exceeds the 15-bit field
    localparam int HEIGHT_CAP   = (MAX_HEIGHT < 32767) ? MAX_HEIGHT : 32767;
    localparam int RESET_HEIGHT = (256 > HEIGHT_CAP) ? HEIGHT_CAP : 256;

    cfg_t         cfg_q;
    cfg_evt_t     cfg_evt;
    shelf_state_t state_reg, state_next, step_state;
    result_t      step_res;
    result_t      rsp_reg;

    // request stage
    logic        req_valid_reg;
    logic        op_reg;
    logic [12:0] rect_width_reg;
    logic [14:0] rect_height_reg;
    logic        rsp_valid_reg;

    logic req_fire;
    logic step_fire;
    logic rsp_room;

    // config writes are always taken
    assign cfg.ready = 1'b1;

    sara_cfg #(
        .HEIGHT_CAP (HEIGHT_CAP)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg_q    (cfg_q),
        .evt      (cfg_evt)
    );

    sara_step #(
        .MAX_WIDTH  (MAX_WIDTH),
        .HEIGHT_CAP (HEIGHT_CAP)
    ) u_step (
        .cfg_q       (cfg_q),
        .st          (state_reg),
        .operation   (op_reg),
        .rect_width  (rect_width_reg),
        .rect_height (rect_height_reg),
        .st_next     (step_state),
        .res         (step_res)
    );

    // handshake: response register frees when taken, request stage moves on
    // whenever the response register has room
    assign rsp_room  = !rsp_valid_reg || rsp.ready;
    assign step_fire = req_valid_reg && rsp_room;
    assign req.ready = !req_valid_reg || step_fire;
    assign req_fire  = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req_fire)
        begin
            req_valid_reg <= 1'b1;
        end
        else if (step_fire)
        begin
            req_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg          <= req.operation;
            rect_width_reg  <= req.rect_width;
            rect_height_reg <= req.rect_height;
        end
    end

    // shelf state: config side effects or the result of a request beat
    always_comb
    begin
        state_next = state_reg;
        if (cfg.valid)
        begin
            if (cfg_evt.load_height)
            begin
                state_next.height_now = cfg_evt.height_value;
            end
            if (cfg_evt.home && !state_reg.anything_placed)
            begin
                state_next.cursor_x    = 13'(cfg_evt.home_x);
                state_next.cursor_y    = 15'(cfg_evt.home_y);
                state_next.row_tallest = '0;
            end
        end
        else if (step_fire)
        begin
            state_next = step_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.cursor_x        <= '0;
            state_reg.cursor_y        <= '0;
            state_reg.row_tallest     <= '0;
            state_reg.height_now      <= 15'(RESET_HEIGHT);
            state_reg.anything_placed <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (step_fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            rsp_reg <= step_res;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = rsp_reg.status;
    assign rsp.offset_x       = rsp_reg.offset_x;
    assign rsp.offset_y       = rsp_reg.offset_y;
    assign rsp.current_height = rsp_reg.current_height;
    assign rsp.grew           = rsp_reg.grew;

endmodule
`default_nettype wire

### src/sara_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sara_cfg
// configuration registers and the side effects of a register write
// ----------------------------------------------------------------------------
module sara_cfg
    import sara_pkg::*;
#(
    parameter int HEIGHT_CAP = 16384
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [14:0] wr_data,
    output cfg_t        cfg_q,
    output cfg_evt_t    evt
);

    localparam wide_t CAP_W = wide_t'(HEIGHT_CAP);

    logic [12:0] atlas_width_reg, atlas_width_next;
    logic [7:0]  pad_x_reg, pad_x_next;
    logic [7:0]  pad_y_reg, pad_y_next;
    logic        growth_locked_reg, growth_locked_next;
    logic [14:0] height_clamped;

    // clamp written height to 1..cap
    always_comb
    begin
        if (wr_data == 15'd0)
        begin
            height_clamped = 15'd1;
        end
        else if (wide_t'(wr_data) > CAP_W)
        begin
            height_clamped = CAP_W[14:0];
        end
        else
        begin
            height_clamped = wr_data;
        end
    end

    // initial height only acts through the atlas height load at write time
    always_comb
    begin
        atlas_width_next    = atlas_width_reg;
        pad_x_next          = pad_x_reg;
        pad_y_next          = pad_y_reg;
        growth_locked_next  = growth_locked_reg;
        evt                 = '0;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_ATLAS_WIDTH:
                begin
                    atlas_width_next = wr_data[12:0];
                end
                REG_INITIAL_HEIGHT:
                begin
                    evt.load_height = 1'b1;
                end
                REG_PAD_X:
                begin
                    pad_x_next = wr_data[7:0];
                    evt.home   = 1'b1;
                end
                REG_PAD_Y:
                begin
                    pad_y_next = wr_data[7:0];
                    evt.home   = 1'b1;
                end
                REG_GROWTH_LOCKED:
                begin
                    growth_locked_next = wr_data[0];
                end
                default:
                begin
                end
            endcase
        end
        evt.height_value = height_clamped;
        evt.home_x       = pad_x_next;
        evt.home_y       = pad_y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atlas_width_reg    <= RESET_ATLAS_WIDTH;
            pad_x_reg          <= 8'd0;
            pad_y_reg          <= 8'd0;
            growth_locked_reg  <= 1'b0;
        end
        else
        begin
            atlas_width_reg    <= atlas_width_next;
            pad_x_reg          <= pad_x_next;
            pad_y_reg          <= pad_y_next;
            growth_locked_reg  <= growth_locked_next;
        end
    end

    assign cfg_q.atlas_width   = atlas_width_reg;
    assign cfg_q.pad_x         = pad_x_reg;
    assign cfg_q.pad_y         = pad_y_reg;
    assign cfg_q.growth_locked = growth_locked_reg;

endmodule
`default_nettype wire

### src/sara_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sara_step
// one request against the shelf state: next state and result
// ----------------------------------------------------------------------------
module sara_step
    import sara_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int HEIGHT_CAP = 16384
)
(
    input  cfg_t         cfg_q,
    input  shelf_state_t st,
    input  logic         operation,
    input  logic [12:0]  rect_width,
    input  logic [14:0]  rect_height,
    output shelf_state_t st_next,
    output result_t      res
);

    localparam wide_t WIDTH_LIM = wide_t'(MAX_WIDTH);
    localparam wide_t CAP_W     = wide_t'(HEIGHT_CAP);

    wide_t       wd, w, h, px, py, cx, cy, rt, hn;
    wide_t       end_x0, end_y0, end_row, row_y_raw, dbl;
    wide_t       cx_e, cy_e, hn_e, rt_e, end_x1, end_y1;
    logic [14:0] row_y;
    logic        bad_size, too_wide, fit_x0, fit_y0, fit_row;
    logic        need_grow, can_grow, grow, row_start;

    assign wd = (wide_t'(cfg_q.atlas_width) > WIDTH_LIM) ? WIDTH_LIM
                                                         : wide_t'(cfg_q.atlas_width);
    assign w  = wide_t'(rect_width);
    assign h  = wide_t'(rect_height);
    assign px = wide_t'(cfg_q.pad_x);
    assign py = wide_t'(cfg_q.pad_y);
    assign cx = wide_t'(st.cursor_x);
    assign cy = wide_t'(st.cursor_y);
    assign rt = wide_t'(st.row_tallest);
    assign hn = wide_t'(st.height_now);

    assign bad_size = (rect_width == 13'd0) || (rect_height == 15'd0);
    assign too_wide = w > wd;

    // fit tests in the current row
    assign end_x0  = cx + w + px;
    assign end_y0  = cy + h + py;
    assign end_row = end_y0 + rt;
    assign fit_x0  = end_x0 <= wd;
    assign fit_y0  = end_y0 <= hn;
    assign fit_row = end_row <= hn;

    // top of the next row, saturated
    assign row_y_raw = cy + rt + py;
    assign row_y     = (row_y_raw > wide_t'(CURSOR_Y_MAX)) ? CURSOR_Y_MAX : row_y_raw[14:0];

    assign dbl       = {hn[16:0], 1'b0};
    assign need_grow = !fit_y0 || (!fit_x0 && !fit_row);
    assign can_grow  = !cfg_q.growth_locked && (dbl <= CAP_W);
    assign grow      = need_grow && can_grow;
    assign row_start = grow || (fit_y0 && !fit_x0 && fit_row);

    // position after any row change or growth
    assign cx_e   = row_start ? px : cx;
    assign cy_e   = row_start ? wide_t'(row_y) : cy;
    assign rt_e   = row_start ? '0 : rt;
    assign hn_e   = grow ? dbl : hn;
    assign end_x1 = cx_e + w + px;
    assign end_y1 = cy_e + h + py;

    always_comb
    begin
        st_next = st;
        res     = '0;
        res.status = ST_OK;
        if (operation == OP_CLEAR)
        begin
            if (st.anything_placed)
            begin
                st_next.cursor_x        = 13'(cfg_q.pad_x);
                st_next.cursor_y        = 15'(cfg_q.pad_y);
                st_next.row_tallest     = '0;
                st_next.anything_placed = 1'b0;
            end
        end
        else if (bad_size)
        begin
            res.status = ST_INVALID;
        end
        else if (too_wide)
        begin
            res.status = ST_OVERFLOW_X;
        end
        else if (need_grow && cfg_q.growth_locked)
        begin
            res.status = ST_LOCKED;
        end
        else if (need_grow && !can_grow)
        begin
            res.status = ST_RESIZE_FAIL;
        end
        else
        begin
            // row change and growth stay even if the rectangle still fails
            if (grow)
            begin
                st_next.height_now = hn_e[14:0];
                res.grew           = 1'b1;
            end
            if (row_start)
            begin
                st_next.cursor_x    = cx_e[12:0];
                st_next.cursor_y    = cy_e[14:0];
                st_next.row_tallest = '0;
            end
            if (end_x1 > wd)
            begin
                res.status = ST_OVERFLOW_X;
            end
            else if (end_y1 > hn_e)
            begin
                res.status = ST_RESIZE_FAIL;
            end
            else
            begin
                res.offset_x = cx_e[11:0];
                res.offset_y = cy_e[13:0];
                st_next.cursor_x = (end_x1 > wide_t'(CURSOR_X_MAX)) ? CURSOR_X_MAX
                                                                     : end_x1[12:0];
                st_next.row_tallest     = (h > rt_e) ? rect_height : rt_e[14:0];
                st_next.anything_placed = 1'b1;
            end
        end
        res.current_height = st_next.height_now;
    end

endmodule
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the shelf atlas rectangle allocator: a shelf
// placement predictor tracks cursor, row and atlas height for every accepted
// request beat and checks each response beat field by field, over directed
// corner cases and randomized rectangle streams under several configurations
// and idle/stall patterns
// ----------------------------------------------------------------------------

package atlas_shelf_tb_pkg;
    import sara_pkg::*;

    localparam int ATLAS_MAX_WIDTH  = 4096;
    localparam int ATLAS_MAX_HEIGHT = 16384;

    class placement_tracker;
        logic [12:0] width_reg;
        logic [14:0] height_reg;
        logic [7:0]  pad_x;
        logic [7:0]  pad_y;
        logic        locked;
        logic [12:0] cur_x;
        logic [14:0] cur_y;
        logic [14:0] row_tallest;
        logic [14:0] height_now;
        logic        placed;
        result_t     pending_placements[$];
        int          errors;

        function new();
            width_reg  = RESET_ATLAS_WIDTH;
            height_reg = RESET_INITIAL_HEIGHT;
            pad_x      = '0;
            pad_y      = '0;
            locked     = 1'b0;
            home();
            height_now = clamp_height(height_reg);
            placed     = 1'b0;
            errors     = 0;
        endfunction

        function int eff_width();
            return (int'(width_reg) > ATLAS_MAX_WIDTH) ? ATLAS_MAX_WIDTH : int'(width_reg);
        endfunction

        function logic [14:0] clamp_height(logic [14:0] v);
            int t;
            t = v;
            if (t < 1) t = 1;
            if (t > ATLAS_MAX_HEIGHT) t = ATLAS_MAX_HEIGHT;
            return 15'(t);
        endfunction

        function void home();
            cur_x       = {5'd0, pad_x};
            cur_y       = {7'd0, pad_y};
            row_tallest = '0;
        endfunction

        function void start_row();
            int s;
            s = int'(cur_y) + int'(row_tallest) + int'(pad_y);
            cur_y       = (s > int'(CURSOR_Y_MAX)) ? CURSOR_Y_MAX : 15'(s);
            cur_x       = {5'd0, pad_x};
            row_tallest = '0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [14:0] data);
            case (idx)
                REG_ATLAS_WIDTH:    width_reg = data[12:0];
                REG_INITIAL_HEIGHT:
                begin
                    height_reg = data;
                    height_now = clamp_height(data);
                end
                REG_PAD_X:
                begin
                    pad_x = data[7:0];
                    if (!placed) home();
                end
                REG_PAD_Y:
                begin
                    pad_y = data[7:0];
                    if (!placed) home();
                end
                REG_GROWTH_LOCKED:  locked = data[0];
                default: ;
            endcase
        endfunction

        // predict the response of one accepted request beat
        function void note_request(logic op, logic [12:0] w, logic [14:0] h);
            result_t r;
            int      ww, hh, px, py, wd, rx, ry, dbl, s;
            bit      resize;
            r = '0;
            r.status = ST_OK;
            ww = w;
            hh = h;
            px = pad_x;
            py = pad_y;
            wd = eff_width();
            if (op == OP_CLEAR) begin
                if (placed) begin
                    home();
                    placed = 1'b0;
                end
            end else if (ww == 0 || hh == 0) begin
                r.status = ST_INVALID;
            end else if (ww > wd) begin
                r.status = ST_OVERFLOW_X;
            end else begin
                rx = wd - int'(cur_x);
                ry = int'(height_now) - int'(cur_y);
                resize = 1'b0;
                if (hh + py > ry) begin
                    resize = 1'b1;
                end else if (ww + px > rx) begin
                    if (hh + py + int'(row_tallest) > ry) resize = 1'b1;
                    else start_row();
                end
                if (resize) begin
                    dbl = int'(height_now) * 2;
                    if (locked) begin
                        r.status = ST_LOCKED;
                    end else if (dbl > ATLAS_MAX_HEIGHT || dbl > int'(CURSOR_Y_MAX)) begin
                        r.status = ST_RESIZE_FAIL;
                    end else begin
                        height_now = 15'(dbl);
                        r.grew = 1'b1;
                        start_row();
                    end
                end
                if (r.status == ST_OK) begin
                    if (int'(cur_x) + ww + px > wd) begin
                        r.status = ST_OVERFLOW_X;
                    end else if (int'(cur_y) + hh + py > int'(height_now)) begin
                        r.status = ST_RESIZE_FAIL;
                    end else begin
                        r.offset_x = 12'(cur_x);
                        r.offset_y = 14'(cur_y);
                        s = int'(cur_x) + ww + px;
                        cur_x = (s > int'(CURSOR_X_MAX)) ? CURSOR_X_MAX : 13'(s);
                        if (h > row_tallest) row_tallest = h;
                        placed = 1'b1;
                    end
                end
            end
            r.current_height = height_now;
            pending_placements.push_back(r);
        endfunction

        function void check_response(result_t got);
            result_t exp;
            if (pending_placements.size() == 0) begin
                $error("response beat with no request pending: status %0d", got.status);
                errors++;
                return;
            end
            exp = pending_placements.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.offset_x !== exp.offset_x) begin
                $error("offset_x: expected %0d, got %0d", exp.offset_x, got.offset_x);
                errors++;
            end
            if (got.offset_y !== exp.offset_y) begin
                $error("offset_y: expected %0d, got %0d", exp.offset_y, got.offset_y);
                errors++;
            end
            if (got.current_height !== exp.current_height) begin
                $error("current_height: expected %0d, got %0d",
                       exp.current_height, got.current_height);
                errors++;
            end
            if (got.grew !== exp.grew) begin
                $error("grew: expected %0d, got %0d", exp.grew, got.grew);
                errors++;
            end
        endfunction
    endclass
endpackage

module tb_top;
    import sara_pkg::*;
    import atlas_shelf_tb_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int SEGMENTS       = 8;
    localparam int SEGMENT_ITEMS  = 144;
    // margin after the last response before touching configuration
    localparam int SETTLE_CYCLES  = 8;

    logic clk = 1'b0;
    logic rst_n;

    // 0 no idling, 1 sender idles, 2 receiver stalls, 3 both lightly
    int idle_mode = 0;
    int cycle_count = 0;

    placement_tracker tracker = new();

    sara_req_if req_ch ();
    sara_rsp_if rsp_ch ();
    sara_cfg_if cfg_ch ();

    shelf_atlas_rect_allocator_core #(
        .MAX_WIDTH  (ATLAS_MAX_WIDTH),
        .MAX_HEIGHT (ATLAS_MAX_HEIGHT)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #1 clk = ~clk;

    // drive one request beat, with random idle cycles ahead of it; valid is
    // left high on return so a following beat goes out back to back
    task automatic send_request(logic op, logic [12:0] w, logic [14:0] h);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 72 : (idle_mode == 3) ? 7 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            // junk payload while idle, the block must ignore it
            req_ch.valid       <= 1'b0;
            req_ch.operation   <= 1'($urandom);
            req_ch.rect_width  <= 13'($urandom);
            req_ch.rect_height <= 15'($urandom);
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= op;
        req_ch.rect_width  <= w;
        req_ch.rect_height <= h;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        tracker.note_request(op, w, h);
    endtask

    // one configuration beat, then a spacer with valid low
    task automatic write_reg(logic [2:0] idx, logic [14:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        tracker.write_reg(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop requests and drain every pending response
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (tracker.pending_placements.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // response side: check accepted beats, stall at random per phase
    always @(posedge clk) begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            tracker.check_response('{status: rsp_ch.status, offset_x: rsp_ch.offset_x,
                                     offset_y: rsp_ch.offset_y,
                                     current_height: rsp_ch.current_height,
                                     grew: rsp_ch.grew});
        rsp_ch.ready <= ($urandom_range(0, 99) >=
                         ((idle_mode == 2) ? 72 : (idle_mode == 3) ? 7 : 0));
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int          seg, k, roll, wd, hcap;
        logic        op;
        logic [12:0] w;
        logic [14:0] h;
        logic [14:0] aw, ih, px, py, lk;

        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.operation   <= OP_PLACE;
        req_ch.rect_width  <= '0;
        req_ch.rect_height <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_ATLAS_WIDTH;
        cfg_ch.data        <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, reset configuration: width 1024, height 256 ----
        // zero sizes are rejected
        send_request(OP_PLACE, 13'd0, 15'd7);
        send_request(OP_PLACE, 13'd9, 15'd0);
        // wider than the atlas, also with every size bit set
        send_request(OP_PLACE, 13'd1025, 15'd1);
        send_request(OP_PLACE, 13'h1FFF, 15'h7FFF);
        // full-width rectangle, then row breaks below the tallest one
        send_request(OP_PLACE, 13'd1024, 15'd16);
        send_request(OP_PLACE, 13'd600, 15'd10);
        send_request(OP_PLACE, 13'd600, 15'd20);
        // vertical overflow doubles the height and opens a row
        send_request(OP_PLACE, 13'd100, 15'd400);
        // grows but still no vertical fit: growth stays, nothing placed
        send_request(OP_PLACE, 13'd10, 15'd2000);
        // clear, then clear on an empty atlas
        send_request(OP_CLEAR, 13'd0, 15'd0);
        send_request(OP_CLEAR, 13'h1FFF, 15'h7FFF);
        settle();

        // pads move the cursor home while nothing is placed; growth locked
        write_reg(REG_PAD_X, 15'd5);
        write_reg(REG_PAD_Y, 15'd3);
        write_reg(REG_GROWTH_LOCKED, 15'd1);
        // new row opened but the padded width still does not fit
        send_request(OP_PLACE, 13'd1020, 15'd8);
        // vertical overflow with growth locked
        send_request(OP_PLACE, 13'd10, 15'd2000);
        send_request(OP_PLACE, 13'd10, 15'd10);
        settle();

        // pad write while something is placed leaves the cursor alone;
        // width above the maximum acts as the maximum, height 0 clamps to 1
        write_reg(REG_PAD_X, 15'd200);
        write_reg(REG_GROWTH_LOCKED, 15'd0);
        write_reg(REG_ATLAS_WIDTH, 15'd8191);
        write_reg(REG_INITIAL_HEIGHT, 15'd0);
        send_request(OP_PLACE, 13'd1, 15'd1);
        settle();

        // height write above the maximum clamps; doubling would pass it
        write_reg(REG_INITIAL_HEIGHT, 15'h7FFF);
        send_request(OP_PLACE, 13'd4096, 15'd16384);
        send_request(OP_CLEAR, 13'd0, 15'd0);
        settle();

        // largest rectangle fills the whole atlas
        write_reg(REG_PAD_X, 15'd0);
        write_reg(REG_PAD_Y, 15'd0);
        send_request(OP_PLACE, 13'd4096, 15'd16384);
        settle();

        // width 0 rejects everything
        write_reg(REG_ATLAS_WIDTH, 15'd0);
        send_request(OP_PLACE, 13'd1, 15'd1);
        settle();

        // grow up to the maximum height, then place into the grown row
        write_reg(REG_ATLAS_WIDTH, 15'd4096);
        write_reg(REG_INITIAL_HEIGHT, 15'd8192);
        send_request(OP_CLEAR, 13'd0, 15'd0);
        send_request(OP_PLACE, 13'd4096, 15'd8192);
        send_request(OP_PLACE, 13'd1, 15'd8192);
        send_request(OP_PLACE, 13'd1, 15'd1);
        settle();

        // ---- random part: configuration per segment, idle phase per pair ----
        for (seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0:
                begin
                    // all extremes high, width clamps to the maximum
                    aw = 15'd8191; ih = 15'h7FFF; px = 15'd255; py = 15'd255; lk = 15'd0;
                end
                1:
                begin
                    // tiny atlas, no padding
                    aw = 15'd1; ih = 15'd1; px = 15'd0; py = 15'd0; lk = 15'd0;
                end
                2:
                begin
                    aw = 15'd4096; ih = 15'd16; px = 15'd0; py = 15'd0; lk = 15'd1;
                end
                default:
                begin
                    aw = ($urandom_range(0, 9) == 0) ? 15'($urandom_range(0, 32767))
                                                     : 15'($urandom_range(16, 4096));
                    ih = 15'($urandom_range(1, 2048));
                    px = ($urandom_range(0, 9) == 0) ? 15'd255 : 15'($urandom_range(0, 12));
                    py = ($urandom_range(0, 9) == 0) ? 15'd255 : 15'($urandom_range(0, 12));
                    lk = ($urandom_range(0, 4) == 0) ? 15'd1 : 15'd0;
                end
            endcase
            idle_mode = 0;
            write_reg(REG_ATLAS_WIDTH, aw);
            write_reg(REG_INITIAL_HEIGHT, ih);
            write_reg(REG_PAD_X, px);
            write_reg(REG_PAD_Y, py);
            write_reg(REG_GROWTH_LOCKED, lk);
            idle_mode = seg / 2;

            for (k = 0; k < SEGMENT_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                wd   = tracker.eff_width();
                op   = OP_PLACE;
                if (roll < 4) begin
                    // clear, size fields are don't-care
                    op = OP_CLEAR;
                    w  = 13'($urandom);
                    h  = 15'($urandom);
                end else if (roll < 7) begin
                    // one dimension zero
                    w = $urandom_range(0, 1) ? 13'd0 : 13'($urandom);
                    h = (w != 0) ? 15'd0 : 15'($urandom);
                end else if (roll < 11) begin
                    // full-range noise
                    w = 13'($urandom_range(0, 8191));
                    h = 15'($urandom_range(0, 32767));
                end else begin
                    // well-formed rectangles sized to the atlas, some wide
                    // enough to break rows and some tall enough to grow
                    if (wd == 0)
                        w = 13'($urandom_range(1, 16));
                    else if (roll < 35)
                        w = 13'($urandom_range(1, wd));
                    else
                        w = 13'($urandom_range(1, (wd > 8) ? wd / 8 : 1));
                    hcap = int'(tracker.height_now) / 8 + 1;
                    if (roll < 20)
                        hcap = int'(tracker.height_now) * 2;
                    if (hcap > 32767)
                        hcap = 32767;
                    h = 15'($urandom_range(1, hcap));
                end
                send_request(op, w, h);
            end
            settle();
        end

        if (tracker.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
